### rtl/lhd_pkg.sv
// Shared types, constants and character tables for the header deframer.
// Used by lhd_front, lhd_queue, lhd_back and lsp_header_deframer; no dependencies.
package lhd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int ACC_W       = LENGTH_BITS + 4;
  localparam int CFG_W       = 32;
  localparam int CMP_W       = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

  localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  localparam logic [1:0] ERR_SEPARATOR = 2'd0;
  localparam logic [1:0] ERR_LENGTH    = 2'd1;
  localparam logic [1:0] ERR_KEY       = 2'd2;
  localparam logic [1:0] ERR_HEADER    = 2'd3;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int KEY_LEN_SIZE  = 14;
  localparam int KEY_TYPE_SIZE = 12;
  localparam int TYPE_SIZE     = 41;

  localparam logic [8*KEY_LEN_SIZE-1:0]  KEY_LEN_TEXT  = "Content-Length";
  localparam logic [8*KEY_TYPE_SIZE-1:0] KEY_TYPE_TEXT = "Content-Type";
  localparam logic [8*TYPE_SIZE-1:0]     TYPE_TEXT     =
    {"application/vs", "code-jsonrpc; charset=utf-8"};

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       last;
    logic [1:0] error_code;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } q_rd_t;

  function automatic logic key_len_ok(input logic [3:0] p, input logic [7:0] c);
    int   idx;
    logic ok;
    ok = 1'b0;
    if (int'(p) < KEY_LEN_SIZE) begin
      idx = KEY_LEN_SIZE - 1 - int'(p);
      ok  = (c == KEY_LEN_TEXT[8*idx +: 8]);
    end
    return ok;
  endfunction

  function automatic logic key_type_ok(input logic [3:0] p, input logic [7:0] c);
    int   idx;
    logic ok;
    ok = 1'b0;
    if (int'(p) < KEY_TYPE_SIZE) begin
      idx = KEY_TYPE_SIZE - 1 - int'(p);
      ok  = (c == KEY_TYPE_TEXT[8*idx +: 8]);
    end
    return ok;
  endfunction

  function automatic logic type_ok(input logic [5:0] p, input logic [7:0] c);
    int   idx;
    logic ok;
    ok = 1'b0;
    if (int'(p) < TYPE_SIZE) begin
      idx = TYPE_SIZE - 1 - int'(p);
      ok  = (c == TYPE_TEXT[8*idx +: 8]);
    end
    return ok;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] lim_of(input logic [CFG_W-1:0] cfg);
    logic [CMP_W-1:0]       e;
    logic [LENGTH_BITS-1:0] r;
    e = CMP_W'(cfg);
    if (e > CMP_W'(LEN_MASK)) begin
      r = LEN_MASK;
    end else begin
      r = e[LENGTH_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/lhd_front.sv
// Front end: takes stream bytes, parses header lines and counts payload bytes.
// Pushes result words into lhd_queue; depends on lhd_pkg.
module lhd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [7:0]                in_data_byte,
  input  logic                      q_full,
  input  logic                      cfg_wr,
  input  logic [lhd_pkg::CFG_W-1:0] cfg_data,
  output lhd_pkg::q_wr_t            q_wr
);

  localparam logic [1:0] PH_KEY     = 2'd0;
  localparam logic [1:0] PH_VALUE   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [1:0] LK_NONE = 2'd0;
  localparam logic [1:0] LK_LEN  = 2'd1;
  localparam logic [1:0] LK_TYPE = 2'd2;

  typedef struct packed {
    logic [1:0]                      phase;
    logic                            line_empty;
    logic                            colon_pending;
    logic [3:0]                      key_pos;
    logic [1:0]                      key_match;
    logic [1:0]                      line_key;
    logic [lhd_pkg::LENGTH_BITS-1:0] acc;
    logic                            digit_seen;
    logic                            bad;
    logic [5:0]                      type_pos;
    logic                            type_match;
  } hdr_t;

  function automatic hdr_t clear_line(input hdr_t s);
    hdr_t r;
    r = s;
    r.phase         = PH_KEY;
    r.line_empty    = 1'b1;
    r.colon_pending = 1'b0;
    r.key_pos       = '0;
    r.key_match     = 2'b11;
    r.line_key      = LK_NONE;
    return r;
  endfunction

  function automatic hdr_t hdr_init();
    hdr_t r;
    r            = '0;
    r            = clear_line(r);
    r.type_match = 1'b1;
    return r;
  endfunction

  function automatic hdr_t key_char(input hdr_t s, input logic [7:0] c);
    hdr_t r;
    r = s;
    if (!lhd_pkg::key_len_ok(s.key_pos, c)) begin
      r.key_match[0] = 1'b0;
    end
    if (!lhd_pkg::key_type_ok(s.key_pos, c)) begin
      r.key_match[1] = 1'b0;
    end
    if (s.key_pos != '1) begin
      r.key_pos = s.key_pos + 4'd1;
    end
    return r;
  endfunction

  function automatic hdr_t start_value(input hdr_t s);
    hdr_t r;
    r = s;
    if (s.key_match[0] && s.key_pos == 4'(lhd_pkg::KEY_LEN_SIZE)) begin
      r.line_key = LK_LEN;
    end else if (s.key_match[1] && s.key_pos == 4'(lhd_pkg::KEY_TYPE_SIZE)) begin
      r.line_key = LK_TYPE;
    end else begin
      r.line_key = LK_NONE;
    end
    r.phase      = PH_VALUE;
    r.acc        = '0;
    r.digit_seen = 1'b0;
    r.bad        = 1'b0;
    r.type_pos   = '0;
    r.type_match = 1'b1;
    return r;
  endfunction

  function automatic hdr_t value_char(input hdr_t s, input logic [7:0] c,
                                      input logic [lhd_pkg::LENGTH_BITS-1:0] lim);
    hdr_t                      r;
    logic [lhd_pkg::ACC_W-1:0] a;
    logic [lhd_pkg::ACC_W-1:0] v;
    r = s;
    a = lhd_pkg::ACC_W'(s.acc);
    v = (a << 3) + (a << 1) + lhd_pkg::ACC_W'(c[3:0]);
    if (s.line_key == LK_LEN) begin
      if (c >= lhd_pkg::CHAR_ZERO && c <= lhd_pkg::CHAR_NINE) begin
        if (v > lhd_pkg::ACC_W'(lim)) begin
          r.bad = 1'b1;
        end else begin
          r.acc = v[lhd_pkg::LENGTH_BITS-1:0];
        end
        r.digit_seen = 1'b1;
      end else begin
        r.bad = 1'b1;
      end
    end else if (s.line_key == LK_TYPE) begin
      if (!lhd_pkg::type_ok(s.type_pos, c)) begin
        r.type_match = 1'b0;
      end
      if (s.type_pos != '1) begin
        r.type_pos = s.type_pos + 6'd1;
      end
    end
    return r;
  endfunction

  function automatic hdr_t line_byte(input hdr_t s, input logic [7:0] c,
                                     input logic [lhd_pkg::LENGTH_BITS-1:0] lim);
    hdr_t r;
    r = s;
    r.line_empty = 1'b0;
    if (s.phase == PH_KEY) begin
      if (s.colon_pending) begin
        r.colon_pending = 1'b0;
        if (c == lhd_pkg::CHAR_SPACE) begin
          return start_value(r);
        end
        r = key_char(r, lhd_pkg::CHAR_COLON);
      end
      if (c == lhd_pkg::CHAR_COLON) begin
        r.colon_pending = 1'b1;
      end else begin
        r = key_char(r, c);
      end
    end else begin
      r = value_char(r, c, lim);
    end
    return r;
  endfunction

  hdr_t                            hdr_r, hdr_nxt, hdr_mid;
  logic                            cr_r, cr_nxt;
  logic [lhd_pkg::LENGTH_BITS-1:0] decl_len_r, decl_len_nxt;
  logic                            decl_ok_r, decl_ok_nxt;
  logic [lhd_pkg::LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [lhd_pkg::LENGTH_BITS-1:0] lim_r, lim_nxt;
  logic                            accept;
  logic                            eol;
  logic                            last;
  logic                            err;
  logic [1:0]                      err_code;

  assign accept = in_valid && !q_full;

  always_comb begin
    lim_nxt = cfg_wr ? lhd_pkg::lim_of(cfg_data) : lim_r;
  end

  always_comb begin
    hdr_nxt      = hdr_r;
    cr_nxt       = cr_r;
    decl_len_nxt = decl_len_r;
    decl_ok_nxt  = decl_ok_r;
    rem_nxt      = rem_r;
    hdr_mid      = hdr_r;
    eol          = 1'b0;
    last         = 1'b0;
    err          = 1'b0;
    err_code     = lhd_pkg::ERR_SEPARATOR;
    q_wr         = '0;
    if (accept) begin
      if (hdr_r.phase == PH_PAYLOAD) begin
        last                  = (rem_r <= lhd_pkg::LENGTH_BITS'(1));
        q_wr.push             = 1'b1;
        q_wr.res.kind         = lhd_pkg::KIND_PAYLOAD;
        q_wr.res.payload_byte = in_data_byte;
        q_wr.res.last         = last;
        q_wr.res.error_code   = lhd_pkg::ERR_SEPARATOR;
        if (last) begin
          rem_nxt = '0;
          hdr_nxt = clear_line(hdr_r);
        end else begin
          rem_nxt = rem_r - lhd_pkg::LENGTH_BITS'(1);
        end
      end else begin
        if (cr_r) begin
          cr_nxt = 1'b0;
          if (in_data_byte == lhd_pkg::CHAR_LF) begin
            eol = 1'b1;
          end else begin
            hdr_mid = line_byte(hdr_mid, lhd_pkg::CHAR_CR, lim_r);
          end
        end
        if (!eol) begin
          if (in_data_byte == lhd_pkg::CHAR_CR) begin
            cr_nxt = 1'b1;
          end else begin
            hdr_mid = line_byte(hdr_mid, in_data_byte, lim_r);
          end
          hdr_nxt = hdr_mid;
        end else begin
          if (hdr_r.line_empty) begin
            if (decl_len_r == '0 || !decl_ok_r) begin
              err      = 1'b1;
              err_code = lhd_pkg::ERR_HEADER;
            end else begin
              rem_nxt       = decl_len_r;
              decl_len_nxt  = '0;
              decl_ok_nxt   = 1'b1;
              hdr_nxt       = clear_line(hdr_r);
              hdr_nxt.phase = PH_PAYLOAD;
            end
          end else if (hdr_r.phase == PH_KEY) begin
            err      = 1'b1;
            err_code = lhd_pkg::ERR_SEPARATOR;
          end else if (hdr_r.line_key == LK_NONE) begin
            err      = 1'b1;
            err_code = lhd_pkg::ERR_KEY;
          end else if (hdr_r.line_key == LK_LEN) begin
            if (!hdr_r.digit_seen || hdr_r.bad) begin
              err      = 1'b1;
              err_code = lhd_pkg::ERR_LENGTH;
            end else begin
              decl_len_nxt = hdr_r.acc;
              hdr_nxt      = clear_line(hdr_r);
            end
          end else begin
            decl_ok_nxt = hdr_r.type_match &&
                          (hdr_r.type_pos == 6'(lhd_pkg::TYPE_SIZE));
            hdr_nxt     = clear_line(hdr_r);
          end
          if (err) begin
            q_wr.push             = 1'b1;
            q_wr.res.kind         = lhd_pkg::KIND_ERROR;
            q_wr.res.payload_byte = '0;
            q_wr.res.last         = 1'b0;
            q_wr.res.error_code   = err_code;
            hdr_nxt               = clear_line(hdr_r);
            decl_len_nxt          = '0;
            decl_ok_nxt           = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= hdr_init();
      cr_r       <= 1'b0;
      decl_len_r <= '0;
      decl_ok_r  <= 1'b1;
      rem_r      <= '0;
      lim_r      <= lhd_pkg::lim_of('1);
    end else begin
      hdr_r      <= hdr_nxt;
      cr_r       <= cr_nxt;
      decl_len_r <= decl_len_nxt;
      decl_ok_r  <= decl_ok_nxt;
      rem_r      <= rem_nxt;
      lim_r      <= lim_nxt;
    end
  end

endmodule

### rtl/lhd_queue.sv
// Short result queue between the parsing front end and the output stage.
// Register-based FIFO of lhd_pkg::res_t words; depends on lhd_pkg.
module lhd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  lhd_pkg::q_wr_t q_wr,
  input  logic           pop,
  output logic           full,
  output lhd_pkg::q_rd_t q_rd
);

  lhd_pkg::res_t              q_r [lhd_pkg::Q_DEPTH];
  logic [lhd_pkg::Q_PTR_W-1:0] wp_r, wp_nxt;
  logic [lhd_pkg::Q_PTR_W-1:0] rp_r, rp_nxt;
  logic [lhd_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == lhd_pkg::Q_CNT_W'(lhd_pkg::Q_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.res   = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (q_wr.push) begin
      wp_nxt = (wp_r == lhd_pkg::Q_PTR_W'(lhd_pkg::Q_DEPTH - 1)) ? '0 :
               wp_r + lhd_pkg::Q_PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == lhd_pkg::Q_PTR_W'(lhd_pkg::Q_DEPTH - 1)) ? '0 :
               rp_r + lhd_pkg::Q_PTR_W'(1);
    end
    case ({q_wr.push, pop})
      2'b10:   cnt_nxt = cnt_r + lhd_pkg::Q_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - lhd_pkg::Q_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      q_r[wp_r] <= q_wr.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/lhd_back.sv
// Output stage: pulls result words from lhd_queue into the output register.
// Drives the result channel; depends on lhd_pkg.
module lhd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lhd_pkg::q_rd_t q_rd,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           out_result_kind,
  output logic [7:0]     out_payload_byte,
  output logic           out_last_of_message,
  output logic [1:0]     out_error_code
);

  logic          out_valid_r, out_valid_nxt;
  lhd_pkg::res_t res_r;
  logic          take;

  assign take          = !out_valid_r || !out_stall;
  assign pop           = take && q_rd.valid;
  assign out_valid_nxt = take ? q_rd.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= q_rd.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = res_r.kind;
  assign out_payload_byte    = res_r.payload_byte;
  assign out_last_of_message = res_r.last;
  assign out_error_code      = res_r.error_code;

endmodule

### rtl/lsp_header_deframer.sv
// Top level of the Content-Length header deframer.
// Instantiates lhd_front, lhd_queue and lhd_back; depends on lhd_pkg.
//
// The block takes one stream byte per cycle while in_stall is low and returns
// at most one word per byte: a payload byte (with a last-of-message flag) or a
// framing error report. The front end parses every byte as it is taken, so
// in_stall rises only when the two-word result queue is full, which happens
// only after out_stall has held the output register. A result passes through
// the queue and then the output register. Header bytes that cause no result
// produce no word. The maximum length register may be written at any time
// through cfg_valid/cfg_ready but takes effect on the next byte and should be
// changed only between messages.
module lsp_header_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_message,
  output logic [1:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_content_length
);

  lhd_pkg::q_wr_t q_wr;
  lhd_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  lhd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_max_content_length),
    .q_wr         (q_wr)
  );

  lhd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  lhd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_rd                (q_rd),
    .pop                 (pop),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_result_kind     (out_result_kind),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_message (out_last_of_message),
    .out_error_code      (out_error_code)
  );

endmodule
